/* hdl/stip_pkg.sv */
// ----------------------------------------------------------------------------
// stip_pkg
// Shared types, constants and helpers of the string-to-integer parser.
// ----------------------------------------------------------------------------
package stip_pkg;

    localparam int BASE_W  = 5;
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int DIGIT_W = 4;

    // Default depth of the queue between the classifier and the accumulator
    localparam int STIP_QUEUE_DEPTH = 2;

    // Supported radix values of the base register
    localparam logic [BASE_W-1:0] BASE_2     = 5'd2;
    localparam logic [BASE_W-1:0] BASE_8     = 5'd8;
    localparam logic [BASE_W-1:0] BASE_10    = 5'd10;
    localparam logic [BASE_W-1:0] BASE_16    = 5'd16;
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_10;

    // ASCII codes used by the classifier
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'd57;  // '9'
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'd70;  // 'F'
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;  // 'a'
    localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'd102; // 'f'
    localparam logic [CHAR_W-1:0] CHAR_SEVEN   = 8'd55;  // '7', offset of 'A'..'F'
    localparam logic [CHAR_W-1:0] CHAR_UPPER_W = 8'd87;  // 'W', offset of 'a'..'f'
    localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'd120; // 'x'
    localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'd88;  // 'X'

    // Radix of a queued digit
    typedef enum logic [1:0] {
        RADIX_2  = 2'd0,
        RADIX_8  = 2'd1,
        RADIX_10 = 2'd2,
        RADIX_16 = 2'd3
    } radix_t;

    // What the accumulator does with a queued request
    typedef enum logic [1:0] {
        KIND_DIGIT = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        radix_t              radix;
        logic [DIGIT_W-1:0]  digit;
    } queue_entry_t;

    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] value;
    } hex_digit_t;

    // Decode one ASCII character as a hex digit
    function automatic hex_digit_t hex_digit(input logic [CHAR_W-1:0] c);
        hex_digit_t         res;
        logic [CHAR_W-1:0]  diff;
        res  = '0;
        diff = '0;
        if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
            diff      = c - CHAR_ZERO;
            res.valid = 1'b1;
        end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
            diff      = c - CHAR_SEVEN;
            res.valid = 1'b1;
        end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
            diff      = c - CHAR_UPPER_W;
            res.valid = 1'b1;
        end
        res.value = diff[DIGIT_W-1:0];
        return res;
    endfunction

endpackage

/* hdl/string_to_integer_base_parser.sv */
// ----------------------------------------------------------------------------
// string_to_integer_base_parser
// Parses an ASCII digit string in radix 2, 8, 10 or 16 into a 32-bit value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready) carries one character per request, or a
//   terminator when s_end_of_string is high. Output channel (m_valid/m_ready)
//   carries one m_value per terminator: the parsed value modulo 2^32, or 0 if
//   any character was not a digit of the radix or the radix is unsupported.
//   cfg_we/cfg_wdata write the radix register (reset value 10); write it only
//   while no request is in flight.
// Timing:
//   One request per cycle while the queue has room. A terminator is written
//   into the classifier queue when it is accepted; the accumulator then loads
//   the result register once a result slot is free.
// Reset and stall:
//   aresetn (synchronous, active low) clears the accumulator, error flag,
//   position and queue and sets the radix to 10. When the receiver stalls,
//   characters keep flowing into the accumulator; a terminator waits in the
//   queue and s_ready drops once the queue fills.
// ----------------------------------------------------------------------------
module string_to_integer_base_parser
    import stip_pkg::*;
#(
    parameter int QUEUE_DEPTH = STIP_QUEUE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [BASE_W-1:0]         cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [CHAR_W-1:0]         s_character,
    input  logic                      s_end_of_string,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_value
);

    localparam int ENTRY_W = $bits(queue_entry_t);

    logic         q_wr_en;
    queue_entry_t q_wr_entry;
    logic         q_full;
    logic         q_valid;
    logic         q_rd_en;
    queue_entry_t q_rd_entry;

    // Classify incoming requests
    stip_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_character     (s_character),
        .s_end_of_string (s_end_of_string),
        .q_wr_en         (q_wr_en),
        .q_wr_entry      (q_wr_entry),
        .q_full          (q_full)
    );

    // Decouple classifier and accumulator
    stip_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_entry),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_rd_en),
        .rd_data  (q_rd_entry)
    );

    // Accumulate and emit results
    stip_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_rd_en (q_rd_en),
        .q_entry (q_rd_entry),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_value (m_value)
    );

endmodule

/* hdl/stip_front.sv */
// ----------------------------------------------------------------------------
// stip_front
// Accepts characters, tracks the position and the radix register, and turns
// each request but a prefix character into a digit, error or terminator entry.
// ----------------------------------------------------------------------------
module stip_front
    import stip_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [BASE_W-1:0]   cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CHAR_W-1:0]   s_character,
    input  logic                s_end_of_string,
    output logic                q_wr_en,
    output queue_entry_t        q_wr_entry,
    input  logic                q_full
);

    logic [BASE_W-1:0] number_base_reg;
    logic [1:0]        position_reg;
    logic [1:0]        position_next;
    logic              accept;
    logic              skip;
    logic              supported;
    radix_t            radix;
    hex_digit_t        dig;
    queue_entry_t      entry;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Map the base register onto a radix code
    always_comb begin
        supported = 1'b1;
        radix     = RADIX_10;
        case (number_base_reg)
            BASE_2:  radix = RADIX_2;
            BASE_8:  radix = RADIX_8;
            BASE_10: radix = RADIX_10;
            BASE_16: radix = RADIX_16;
            default: supported = 1'b0;
        endcase
    end

    // Classify the character
    always_comb begin
        dig  = hex_digit(s_character);
        skip = 1'b0;
        if (number_base_reg == BASE_8 && position_reg == 2'd0 &&
            s_character == CHAR_ZERO) begin
            skip = 1'b1;
        end
        if (number_base_reg == BASE_16 &&
            ((position_reg == 2'd0 && s_character == CHAR_ZERO) ||
             (position_reg == 2'd1 && (s_character == CHAR_LOWER_X ||
                                       s_character == CHAR_UPPER_X)))) begin
            skip = 1'b1;
        end

        entry.radix = radix;
        entry.digit = dig.value;
        if (s_end_of_string) begin
            entry.kind = KIND_END;
        end else if (!supported || !dig.valid ||
                     {1'b0, dig.value} >= number_base_reg) begin
            entry.kind = KIND_ERROR;
        end else begin
            entry.kind = KIND_DIGIT;
        end
    end

    // Drop prefix characters, queue everything else
    assign q_wr_en    = accept && (s_end_of_string || !skip);
    assign q_wr_entry = entry;

    // Advance the position, saturating at two; clear it on a terminator
    always_comb begin
        position_next = position_reg;
        if (accept) begin
            if (s_end_of_string) begin
                position_next = 2'd0;
            end else if (position_reg != 2'd2) begin
                position_next = position_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_base_reg <= BASE_RESET;
            position_reg    <= 2'd0;
        end else begin
            position_reg <= position_next;
            if (cfg_we) begin
                number_base_reg <= cfg_wdata;
            end
        end
    end

endmodule

/* hdl/stip_fifo.sv */
// ----------------------------------------------------------------------------
// stip_fifo
// Small register queue between the classifier and the accumulator.
// ----------------------------------------------------------------------------
module stip_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    output logic             rd_valid,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == CNT_DEPTH);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the written entry
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_DEPTH)
        else $error("queue occupancy above depth");

    // A write without a read grows the occupancy by one
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_wr && !do_rd) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on write");

    // A read without a write shrinks the occupancy by one
    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_rd && !do_wr) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not shrink on read");

endmodule

/* hdl/stip_back.sv */
// ----------------------------------------------------------------------------
// stip_back
// Accumulates queued digits, records errors and drives the result register.
// ----------------------------------------------------------------------------
module stip_back
    import stip_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_rd_en,
    input  queue_entry_t              q_entry,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_value
);

    logic [VALUE_W-1:0]        acc_reg;
    logic [VALUE_W-1:0]        acc_next;
    logic [VALUE_W-1:0]        acc_scaled;
    logic                      err_reg;
    logic                      err_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic signed [VALUE_W-1:0] m_value_reg;
    logic signed [VALUE_W-1:0] m_value_next;
    logic                      slot_free;
    logic                      take;
    logic                      take_end;

    // A terminator waits for a free result slot, other requests never stall
    assign slot_free = !m_valid_reg || m_ready;
    assign q_rd_en   = q_valid && (q_entry.kind != KIND_END || slot_free);
    assign take      = q_rd_en;
    assign take_end  = take && q_entry.kind == KIND_END;

    // Scale the accumulator by the radix
    always_comb begin
        case (q_entry.radix)
            RADIX_2:  acc_scaled = acc_reg << 1;
            RADIX_8:  acc_scaled = acc_reg << 3;
            RADIX_10: acc_scaled = (acc_reg << 3) + (acc_reg << 1);
            RADIX_16: acc_scaled = acc_reg << 4;
            default:  acc_scaled = acc_reg << 4;
        endcase
    end

    // Apply the request
    always_comb begin
        acc_next     = acc_reg;
        err_next     = err_reg;
        m_value_next = m_value_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (take) begin
            case (q_entry.kind)
                KIND_DIGIT: begin
                    acc_next = acc_scaled + VALUE_W'(q_entry.digit);
                end
                KIND_ERROR: begin
                    err_next = 1'b1;
                end
                KIND_END: begin
                    m_value_next = err_reg ? '0 : $signed(acc_reg);
                    m_valid_next = 1'b1;
                    acc_next     = '0;
                    err_next     = 1'b0;
                end
                default: begin
                    err_next = err_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    // A taken terminator always shows a result next cycle
    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        take_end |=> m_valid_reg)
        else $error("terminator taken without a result");

    // A taken terminator clears the running state
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take_end |=> (acc_reg == '0 && !err_reg))
        else $error("state not cleared after terminator");

    // An error string reports zero
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (take_end && err_reg) |=> m_value_reg == '0)
        else $error("error string gave a nonzero value");

endmodule

/* tb/sv/string_to_integer_base_parser_checker.sv */
// ----------------------------------------------------------------------------
// string_to_integer_base_parser_checker
// Watches the radix register port and both channels of the parser. Each
// character request updates a parsed-value predictor, and each terminator
// queues the value that the result channel must return. Results are checked
// in order against that queue.
// ----------------------------------------------------------------------------
module string_to_integer_base_parser_checker
    import stip_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [BASE_W-1:0]         cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [CHAR_W-1:0]         s_character,
    input  logic                      s_end_of_string,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [VALUE_W-1:0] m_value,
    output int                        fail_count,
    output int                        pending,
    output int                        checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted parser state
    logic [BASE_W-1:0]  radix;
    logic [VALUE_W-1:0] running_value;
    logic               bad_char_seen;
    logic [1:0]         char_pos;

    // Parsed values still owed by the result channel, oldest first
    logic [VALUE_W-1:0] owed_values[$];

    // Value of an ASCII hex digit, or -1 for anything else
    function automatic int char_digit(input logic [CHAR_W-1:0] ch);
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) return int'(ch - CHAR_ZERO);
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) return int'(ch - CHAR_SEVEN);
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F) return int'(ch - CHAR_UPPER_W);
        return -1;
    endfunction

    // Fold one character into the running value under the current radix
    task automatic absorb_char(input logic [CHAR_W-1:0] ch);
        int   digit;
        logic octal_lead;
        logic hex_lead;
        logic supported;
        octal_lead = (radix == BASE_8) && (char_pos == 2'd0) && (ch == CHAR_ZERO);
        hex_lead   = (radix == BASE_16) &&
                     (((char_pos == 2'd0) && (ch == CHAR_ZERO)) ||
                      ((char_pos == 2'd1) &&
                       ((ch == CHAR_LOWER_X) || (ch == CHAR_UPPER_X))));
        supported  = (radix == BASE_2) || (radix == BASE_8) ||
                     (radix == BASE_10) || (radix == BASE_16);
        digit      = char_digit(ch);
        if (octal_lead || hex_lead) begin
            // skip the prefix character
        end else if (!supported) begin
            bad_char_seen = 1'b1;
        end else if (digit < 0 || digit >= int'(radix)) begin
            bad_char_seen = 1'b1;
        end else begin
            running_value = running_value * VALUE_W'(radix) + VALUE_W'(digit);
        end
        if (char_pos < 2'd2) char_pos = char_pos + 2'd1;
    endtask

    task automatic report_failure(input string what, input logic [VALUE_W-1:0] want);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] %s: expected %0d (0x%08h), got %0d (0x%08h)", $realtime, what,
                     $signed(want), want, m_value, m_value);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            radix         = BASE_RESET;
            running_value = '0;
            bad_char_seen = 1'b0;
            char_pos      = 2'd0;
            fail_count    = 0;
            checked       = 0;
            owed_values.delete();
        end else begin
            // Track radix writes; users keep them to parser idle, unenforced
            if (cfg_we) radix = cfg_wdata;

            // Predict from each accepted request
            if (s_valid && s_ready) begin
                if (s_end_of_string) begin
                    owed_values.push_back(bad_char_seen ? '0 : running_value);
                    running_value = '0;
                    bad_char_seen = 1'b0;
                    char_pos      = 2'd0;
                end else begin
                    absorb_char(s_character);
                end
            end

            // Compare each accepted result with the oldest owed value
            if (m_valid && m_ready) begin
                if (owed_values.size() == 0) begin
                    report_failure("result with nothing owed", 'x);
                end else begin
                    logic [VALUE_W-1:0] want;
                    want = owed_values.pop_front();
                    checked++;
                    if (m_value !== want) report_failure("m_value mismatch", want);
                end
            end
        end
        pending = owed_values.size();
    end

endmodule

/* tb/sv/string_to_integer_base_parser_test.sv */
// ----------------------------------------------------------------------------
// string_to_integer_base_parser_test
// Drives character strings and terminators into the parser under a series of
// radix settings, supported and unsupported, with random idle cycles on both
// channels. A checker beside the parser predicts and compares every result.
// ----------------------------------------------------------------------------
module string_to_integer_base_parser_test;
    import stip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_ITEMS = 1450;

    logic                      aclk;
    logic                      aresetn         = 1'b0;
    logic                      cfg_we          = 1'b0;
    logic [BASE_W-1:0]         cfg_wdata       = '0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic [CHAR_W-1:0]         s_character     = '0;
    logic                      s_end_of_string = 1'b0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic signed [VALUE_W-1:0] m_value;

    int                fail_count;
    int                pending;
    int                checked;
    int                items_sent   = 0;
    int                radix_writes = 0;
    bit                idling       = 1'b1;
    logic [BASE_W-1:0] cur_radix    = BASE_RESET;

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    string_to_integer_base_parser i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_character     (s_character),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value         (m_value)
    );

    string_to_integer_base_parser_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_character     (s_character),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value         (m_value),
        .fail_count      (fail_count),
        .pending         (pending),
        .checked         (checked)
    );

    // Stall the result channel at random while idling is on
    always @(posedge aclk) begin
        m_ready <= !(idling && $urandom_range(99, 0) < 14);
    end

    // Present one request and hold it until accepted
    task automatic send_request(input logic [CHAR_W-1:0] ch, input logic eos);
        while (idling && $urandom_range(99, 0) < 14) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_character     <= ch;
        s_end_of_string <= eos;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_text(input string text, input bit terminate);
        for (int i = 0; i < text.len(); i++) send_request(text[i], 1'b0);
        if (terminate) send_request(CHAR_W'($urandom), 1'b1);
    endtask

    // Hold off until every owed result is back and the pipeline has settled
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_radix(input logic [BASE_W-1:0] r);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_radix = r;
        radix_writes++;
    endtask

    // Random digit of the current radix, mixed case for letters
    function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] r);
        int span;
        int d;
        span = (r == BASE_2) ? 2 : (r == BASE_8) ? 8 : (r == BASE_10) ? 10 : 16;
        d    = $urandom_range(span - 1, 0);
        if (d < 10) return CHAR_ZERO + CHAR_W'(d);
        return ($urandom_range(1, 0) ? CHAR_LOWER_A : CHAR_UPPER_A) + CHAR_W'(d - 10);
    endfunction

    // One terminated number: optional prefix, digits, sometimes a stray byte
    task automatic send_number();
        int len;
        bit noisy;
        len   = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 0);
        noisy = ($urandom_range(99, 0) < 15);
        if (cur_radix == BASE_16 && $urandom_range(2, 0) == 0) begin
            send_request(CHAR_ZERO, 1'b0);
            send_request($urandom_range(1, 0) ? CHAR_LOWER_X : CHAR_UPPER_X, 1'b0);
        end else if (cur_radix == BASE_8 && $urandom_range(2, 0) == 0) begin
            send_request(CHAR_ZERO, 1'b0);
        end
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(99, 0) < 20) send_request(CHAR_W'($urandom), 1'b0);
            else send_request(digit_char(cur_radix), 1'b0);
        end
        send_request(CHAR_W'($urandom), 1'b1);
    endtask

    function automatic logic [BASE_W-1:0] phase_radix(input int phase);
        case (phase)
            0:       return BASE_10;
            1:       return BASE_16;
            2:       return BASE_2;
            3:       return BASE_8;
            4:       return 5'd31;
            5:       return BASE_16;
            6:       return 5'd0;
            7:       return BASE_10;
            8:       return BASE_8;
            9:       return BASE_2;
            10:      return 5'd3;
            11:      return BASE_16;
            default: return BASE_W'($urandom_range(31, 0));
        endcase
    endfunction

    initial begin
        #(4_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int               phase;
        int               start;
        int               budget;
        bit               paused;
        logic [BASE_W-1:0] r;
        phase  = 0;
        paused = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: character extremes under the reset radix
        send_request(8'h00, 1'b0);
        send_request(8'hA5, 1'b1);
        send_request(8'hFF, 1'b0);
        send_request(8'h5A, 1'b1);
        send_text("99", 1'b1);
        // Hex prefix, and 'X' at position one without a leading zero
        write_radix(BASE_16);
        send_text("0x1F", 1'b1);
        send_text("7Xa", 1'b1);
        // Octal leading zero
        write_radix(BASE_8);
        send_text("017", 1'b1);
        // Radix changed in the middle of a string
        write_radix(BASE_2);
        send_text("1", 1'b0);
        write_radix(BASE_16);
        send_text("f", 1'b1);
        // Unsupported radix at both ends of the register, empty string too
        write_radix(5'd0);
        send_text("1", 1'b1);
        send_request(8'h00, 1'b1);
        write_radix(5'd31);
        send_request(8'hFF, 1'b1);

        // Random phases, one radix setting each
        while (items_sent < 26 + RANDOM_ITEMS) begin
            r = phase_radix(phase);
            // Sometimes leave a string open across the radix change
            if ($urandom_range(2, 0) == 0) begin
                repeat ($urandom_range(3, 1)) send_request(digit_char(cur_radix), 1'b0);
            end
            write_radix(r);
            idling = (phase != 3);
            budget = ((r == BASE_2) || (r == BASE_8) || (r == BASE_10) || (r == BASE_16))
                     ? 200 : 40;
            start  = items_sent;
            while (items_sent - start < budget && items_sent < 26 + RANDOM_ITEMS) begin
                send_number();
                if (phase == 1 && !paused && items_sent - start > 100) begin
                    drain();
                    paused = 1'b1;
                end
            end
            phase++;
        end

        idling = 1'b1;
        drain();

        $display("covered %0d requests over %0d radix writes, %0d results compared",
                 items_sent, radix_writes, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/stip_pkg.sv
hdl/stip_front.sv
hdl/stip_fifo.sv
hdl/stip_back.sv
hdl/string_to_integer_base_parser.sv
tb/sv/string_to_integer_base_parser_checker.sv
tb/sv/string_to_integer_base_parser_test.sv
